/* rtl/bgpm_pkg.sv */
// Shared types, constants and helper functions for the ghost particle mirror.
// Used by every module of the block but the queue; no dependencies of its own.
package bgpm_pkg;

  localparam int FIELD_W     = 32;
  localparam int NUM_AXES    = 3;
  localparam int NUM_SUBSETS = 7;
  localparam int DATA_W      = 7 * FIELD_W;   // seven 32-bit fields, already whole bytes
  localparam int CUT_W       = 31;
  localparam int SCALE_W     = 16;
  localparam int REG_IDX_W   = 3;

  localparam int MIRROR_GAP_DEF  = 0;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BOX_MIN_X     = 3'd0,
    REG_BOX_MIN_Y     = 3'd1,
    REG_BOX_MIN_Z     = 3'd2,
    REG_BOX_MAX_X     = 3'd3,
    REG_BOX_MAX_Y     = 3'd4,
    REG_BOX_MAX_Z     = 3'd5,
    REG_CUTOFF        = 3'd6,
    REG_PRESSURE_SCALE = 3'd7
  } reg_index_t;

  // Ghost emission order: depth first by lowest axis
  localparam logic [NUM_AXES-1:0] SUBSET_ORDER [NUM_SUBSETS] =
    '{3'b001, 3'b011, 3'b111, 3'b101, 3'b010, 3'b110, 3'b100};

  typedef struct packed {
    logic [NUM_AXES-1:0][FIELD_W-1:0] box_min;
    logic [NUM_AXES-1:0][FIELD_W-1:0] box_max;
    logic [CUT_W-1:0]                 cutoff;
    logic [SCALE_W-1:0]               pscale;
  } cfg_t;

  // One classified particle, handed from front to back
  typedef struct packed {
    logic [NUM_AXES-1:0][FIELD_W-1:0] pos;
    logic [NUM_AXES-1:0][FIELD_W-1:0] mpos;
    logic [NUM_AXES-1:0][FIELD_W-1:0] vel;
    logic [NUM_AXES-1:0][FIELD_W-1:0] nvel;
    logic [FIELD_W-1:0]               pressure;
    logic [NUM_AXES-1:0]              hit;
  } ghost_src_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic [FIELD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sh0000_0000_7FFF_FFFF;
    lo_lim = -64'sh0000_0000_8000_0000;
    if (v > hi_lim)      sat32 = 32'h7FFF_FFFF;
    else if (v < lo_lim) sat32 = 32'h8000_0000;
    else                 sat32 = v[FIELD_W-1:0];
  endfunction

  // Which order slots a hit mask produces
  function automatic logic [NUM_SUBSETS-1:0] subset_slots(input logic [NUM_AXES-1:0] hit);
    logic [NUM_SUBSETS-1:0] s;
    for (int k = 0; k < NUM_SUBSETS; k++) begin
      s[k] = ((SUBSET_ORDER[k] & hit) == SUBSET_ORDER[k]);
    end
    subset_slots = s;
  endfunction

endpackage

/* rtl/bgpm_queue.sv */
// Small flip-flop FIFO between the classify front and the ghost emitter.
// Depends on nothing; width and depth come from parameters.
module bgpm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/bgpm_front.sv */
// Classify front: wall distance tests, mirrored positions, negated velocities
// and scaled pressure over two pipeline stages. Depends on bgpm_pkg.
module bgpm_front
  import bgpm_pkg::*;
#(
  parameter int MIRROR_GAP = MIRROR_GAP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ghost_src_t        out_data
);

  localparam logic signed [35:0] GAP = 36'(MIRROR_GAP);

  // Stage 1 registers
  logic                             s1_valid;
  logic [NUM_AXES-1:0][FIELD_W-1:0] s1_pos;
  logic [NUM_AXES-1:0][FIELD_W-1:0] s1_vel;
  logic signed [33:0]               s1_dmin [NUM_AXES];
  logic signed [33:0]               s1_dmax [NUM_AXES];
  logic [NUM_AXES-1:0]              s1_hitlo;
  logic [NUM_AXES-1:0]              s1_hithi;
  logic signed [48:0]               s1_prod;

  // Stage 2 register
  logic       s2_valid;
  ghost_src_t s2_data;

  logic                             advance;
  logic signed [33:0]               dmin [NUM_AXES];
  logic signed [33:0]               dmax [NUM_AXES];
  logic [NUM_AXES-1:0]              hitlo;
  logic [NUM_AXES-1:0]              hithi;
  logic signed [48:0]               prod;
  ghost_src_t                       s2_next;

  // Hold both stages while a particle with ghosts waits on the queue
  assign advance   = !s2_valid || (s2_data.hit == '0) || out_ready;
  assign in_ready  = advance;
  assign out_valid = s2_valid && (s2_data.hit != '0);
  assign out_data  = s2_data;

  // Stage 1: wall distances at 34 bits and the pressure product
  always_comb begin
    logic signed [33:0] p;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] cut;
    cut = {3'b000, cfg.cutoff};
    for (int a = 0; a < NUM_AXES; a++) begin
      p  = 34'($signed(in_data[a*FIELD_W +: FIELD_W]));
      lo = 34'($signed(cfg.box_min[a]));
      hi = 34'($signed(cfg.box_max[a]));
      dmin[a]  = p - lo;
      dmax[a]  = hi - p;
      hitlo[a] = dmin[a] < cut;
      hithi[a] = dmax[a] < cut;
    end
    prod = $signed(in_data[6*FIELD_W +: FIELD_W]) * $signed({1'b0, cfg.pscale});
  end

  // Stage 2: mirror, saturate, negate, round pressure
  always_comb begin
    logic signed [35:0] lo;
    logic signed [35:0] hi;
    logic signed [35:0] mlo;
    logic signed [35:0] mhi;
    logic signed [49:0] pr;
    logic signed [FIELD_W-1:0] v;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo  = 36'($signed(cfg.box_min[a]));
      hi  = 36'($signed(cfg.box_max[a]));
      mlo = lo - 36'(s1_dmin[a]) - GAP;
      mhi = hi + 36'(s1_dmax[a]) + GAP;
      s2_next.pos[a] = s1_pos[a];
      s2_next.vel[a] = s1_vel[a];
      if (s1_hitlo[a]) begin
        s2_next.mpos[a] = sat32(64'(mlo));
      end else if (s1_hithi[a]) begin
        s2_next.mpos[a] = sat32(64'(mhi));
      end else begin
        s2_next.mpos[a] = s1_pos[a];
      end
      v = $signed(s1_vel[a]);
      s2_next.nvel[a] = (s1_vel[a] == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'(-v);
    end
    s2_next.hit = s1_hitlo | s1_hithi;
    pr = 50'(s1_prod) + 50'sd128;
    s2_next.pressure = sat32(64'(pr >>> 8));
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        s1_pos[a]  <= in_data[a*FIELD_W +: FIELD_W];
        s1_vel[a]  <= in_data[(3+a)*FIELD_W +: FIELD_W];
        s1_dmin[a] <= dmin[a];
        s1_dmax[a] <= dmax[a];
      end
      s1_hitlo <= hitlo;
      s1_hithi <= hithi;
      s1_prod  <= prod;
      s2_data  <= s2_next;
    end
  end

  // Advance pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

endmodule

/* rtl/bgpm_back.sv */
// Ghost emitter: walks the hit subsets of one particle in order, one ghost
// per beat, into a registered output stage. Depends on bgpm_pkg.
module bgpm_back
  import bgpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghost_src_t          in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_data,
  output logic [NUM_AXES-1:0] out_axes,
  output logic                out_last
);

  ghost_src_t             hold;
  logic                   hold_valid;
  logic [NUM_SUBSETS-1:0] rem;

  logic                   emit;
  logic [2:0]             cur_k;
  logic [NUM_AXES-1:0]    cur_mask;
  logic [NUM_SUBSETS-1:0] rem_next;
  logic                   is_last;
  logic [DATA_W-1:0]      ghost;

  assign emit     = hold_valid && (!out_valid || out_ready);
  assign rem_next = rem & (rem - 1'b1);
  assign is_last  = (rem_next == '0);
  assign in_ready = !hold_valid || (emit && is_last);
  assign cur_mask = SUBSET_ORDER[cur_k];

  // Pick the lowest pending slot
  always_comb begin
    cur_k = '0;
    for (int k = NUM_SUBSETS - 1; k >= 0; k--) begin
      if (rem[k]) cur_k = 3'(k);
    end
  end

  // Assemble the ghost for the current subset
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ghost[a*FIELD_W +: FIELD_W]     = cur_mask[a] ? hold.mpos[a] : hold.pos[a];
      ghost[(3+a)*FIELD_W +: FIELD_W] = cur_mask[a] ? hold.nvel[a] : hold.vel[a];
    end
    ghost[6*FIELD_W +: FIELD_W] = hold.pressure;
  end

  // Load the next particle, retire slots
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rem        <= '0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
      rem        <= subset_slots(in_data.hit);
    end else if (emit) begin
      rem <= rem_next;
      if (is_last) hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= ghost;
      out_axes <= cur_mask;
      out_last <= is_last;
    end
  end

endmodule

/* rtl/boundary_ghost_particle_mirror.sv */
// Top level of the mirror ghost particle generator: configuration registers,
// classify front, queue and ghost emitter. Depends on bgpm_pkg and the bgpm_* modules.
//
// Usage:
//   Slave stream s_*: one owned particle per beat (positions, velocities, pressure).
//   Master stream m_*: one ghost per beat; tuser holds the mirrored axis mask,
//   tlast marks the last ghost of a particle. Particles with no wall within
//   the cutoff produce no beat at all.
//   Config port: cfg_we/cfg_index/cfg_data writes one register per cycle; write
//   only while no particle is in flight.
// Path: the edge accepting an input beat is followed by front stage 2, the queue write,
//   the emitter load and the output register before the first ghost is valid.
// Throughput: one particle per cycle when it makes at most one ghost and m_tready stays
//   high; a particle with n ghosts holds the emitter while it sends them, one ghost per
//   cycle while m_tready is high, and the queue of QUEUE_DEPTH particles lets the front keep accepting meanwhile.
// Reset (rst, synchronous): registers return to a box of [0, 1.0) on each axis,
//   cutoff 0.1, pressure scale 1.0; all pipeline, queue and output state empties.
// Stall: when m_tready is low the output beat holds, the emitter and queue fill,
//   and s_tready drops once a particle with ghosts cannot enter the queue.
module boundary_ghost_particle_mirror
  import bgpm_pkg::*;
#(
  parameter int MIRROR_GAP  = MIRROR_GAP_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Particle input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, pressure_in
  // Ghost output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // ghost_pos_x/y/z, ghost_vel_x/y/z, ghost_pressure
  output logic [NUM_AXES-1:0]  m_tuser,   // mirrored_axes
  output logic                 m_tlast,   // last_ghost
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  cfg_t       cfg;
  logic       fr_valid;
  logic       fr_ready;
  ghost_src_t fr_data;
  logic       q_valid;
  logic       q_ready;
  ghost_src_t q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_min <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        cfg.box_max[a] <= 32'h0001_0000;
      end
      cfg.cutoff <= 31'd6554;
      cfg.pscale <= 16'd256;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BOX_MIN_X:      cfg.box_min[0] <= cfg_data;
        REG_BOX_MIN_Y:      cfg.box_min[1] <= cfg_data;
        REG_BOX_MIN_Z:      cfg.box_min[2] <= cfg_data;
        REG_BOX_MAX_X:      cfg.box_max[0] <= cfg_data;
        REG_BOX_MAX_Y:      cfg.box_max[1] <= cfg_data;
        REG_BOX_MAX_Z:      cfg.box_max[2] <= cfg_data;
        REG_CUTOFF:         cfg.cutoff     <= cfg_data[CUT_W-1:0];
        REG_PRESSURE_SCALE: cfg.pscale     <= cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  bgpm_front #(
    .MIRROR_GAP (MIRROR_GAP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  bgpm_queue #(
    .WIDTH ($bits(ghost_src_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  bgpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_axes  (m_tuser),
    .out_last  (m_tlast)
  );

`ifndef SYNTHESIS
  // Every ghost carries at least one mirrored axis
  a_axes_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != '0))
    else $error("ghost beat with empty axis mask");

  // Output stage is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // Input stalls only because a particle with ghosts cannot enter the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (fr_valid && !fr_ready))
    else $error("input stalled without a blocked queue write");

  // Hold the ghost beat while the receiver stalls
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("ghost beat changed while stalled");
`endif

endmodule

/* tb/ghost_mirror_checker.sv */
// Scoreboard for the ghost particle mirror: shadows the configuration writes,
// predicts the ghosts of every accepted particle and compares the ghost beats.
// Depends on bgpm_pkg for the bus widths and register indexes.
module ghost_mirror_checker
  import bgpm_pkg::*;
#(
  parameter int GAP = MIRROR_GAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [DATA_W-1:0]    m_tdata,
  input  logic [NUM_AXES-1:0]  m_tuser,
  input  logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   ghosts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // One ghost: words are pos x/y/z, vel x/y/z, pressure, lowest first
  typedef struct packed {
    logic [6:0][FIELD_W-1:0] word;
    logic [NUM_AXES-1:0]     axes;
    logic                    last;
  } ghost_t;

  // Subsets of the hit axes in emission order
  localparam logic [NUM_AXES-1:0] EMIT_ORDER [7] =
    '{3'b001, 3'b011, 3'b111, 3'b101, 3'b010, 3'b110, 3'b100};

  // Ring of predicted ghosts, far deeper than what can be in flight
  localparam int DUE_W     = 10;
  localparam int DUE_DEPTH = 1 << DUE_W;

  string field_name [7] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                            "pressure"};

  logic [FIELD_W-1:0] wall_lo [NUM_AXES];
  logic [FIELD_W-1:0] wall_hi [NUM_AXES];
  logic [CUT_W-1:0]   cutoff;
  logic [SCALE_W-1:0] pscale;

  ghost_t           ghosts_due [DUE_DEPTH];
  logic [DUE_W-1:0] due_rd = '0;
  logic [DUE_W-1:0] due_wr = '0;
  int               due_count = 0;
  ghost_t           exp_ghost;
  ghost_t           got_ghost;
  logic             bad;

  function automatic logic [FIELD_W-1:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[FIELD_W-1:0];
  endfunction

  // Mirror each axis against its walls and queue one ghost per hit subset
  task automatic predict_ghosts(input logic [DATA_W-1:0] beat);
    logic signed [63:0]      p, lo, hi, dlo, dhi, cut, pr, sc, prod;
    logic [2:0][FIELD_W-1:0] pos, vel, mpos, mvel;
    logic [FIELD_W-1:0]      gp;
    logic [NUM_AXES-1:0]     hit;
    ghost_t                  g;
    int                      total, n;
    hit = '0;
    cut = {33'd0, cutoff};
    for (int a = 0; a < NUM_AXES; a++) begin
      pos[a]  = beat[a*FIELD_W +: FIELD_W];
      vel[a]  = beat[(3+a)*FIELD_W +: FIELD_W];
      mpos[a] = pos[a];
      mvel[a] = (vel[a] == 32'h8000_0000) ? 32'h7FFF_FFFF : -vel[a];
      p   = $signed(pos[a]);
      lo  = $signed(wall_lo[a]);
      hi  = $signed(wall_hi[a]);
      dlo = p - lo;
      dhi = hi - p;
      // lower wall takes precedence when both are close
      if (dlo < cut) begin
        mpos[a] = clamp32(lo - dlo - GAP);
        hit[a]  = 1'b1;
      end else if (dhi < cut) begin
        mpos[a] = clamp32(hi + dhi + GAP);
        hit[a]  = 1'b1;
      end
    end
    // scale pressure, round half up, saturate
    pr   = $signed(beat[6*FIELD_W +: FIELD_W]);
    sc   = {48'd0, pscale};
    prod = pr * sc + 64'sd128;
    gp   = clamp32(prod >>> 8);
    total = 0;
    for (int k = 0; k < 7; k++)
      if ((EMIT_ORDER[k] & hit) == EMIT_ORDER[k]) total++;
    n = 0;
    for (int k = 0; k < 7; k++) begin
      if ((EMIT_ORDER[k] & hit) == EMIT_ORDER[k]) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          g.word[a]   = EMIT_ORDER[k][a] ? mpos[a] : pos[a];
          g.word[3+a] = EMIT_ORDER[k][a] ? mvel[a] : vel[a];
        end
        g.word[6] = gp;
        g.axes    = EMIT_ORDER[k];
        n++;
        g.last    = (n == total);
        ghosts_due[due_wr] = g;
        due_wr    = due_wr + 1'b1;
        due_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        wall_lo[a] = 32'h0000_0000;
        wall_hi[a] = 32'h0001_0000;
      end
      cutoff = 31'd6554;
      pscale = 16'd256;
      due_rd = '0;
      due_wr = '0;
      due_count = 0;
      mismatches = 0;
    end else begin
      // shadow register writes
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_BOX_MIN_X:      wall_lo[0] = cfg_data;
          REG_BOX_MIN_Y:      wall_lo[1] = cfg_data;
          REG_BOX_MIN_Z:      wall_lo[2] = cfg_data;
          REG_BOX_MAX_X:      wall_hi[0] = cfg_data;
          REG_BOX_MAX_Y:      wall_hi[1] = cfg_data;
          REG_BOX_MAX_Z:      wall_hi[2] = cfg_data;
          REG_CUTOFF:         cutoff = cfg_data[CUT_W-1:0];
          REG_PRESSURE_SCALE: pscale = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_ghosts(s_tdata);
      // compare the ghost beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        got_ghost.word = m_tdata;
        got_ghost.axes = m_tuser;
        got_ghost.last = m_tlast;
        if (due_count == 0) begin
          if (mismatches < 10)
            $display("%0t: ghost beat with none expected: data %h axes %b last %b",
                     $realtime, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          exp_ghost = ghosts_due[due_rd];
          due_rd    = due_rd + 1'b1;
          due_count--;
          bad = 1'b0;
          for (int f = 0; f < 7; f++) begin
            if (exp_ghost.word[f] !== got_ghost.word[f]) begin
              if (mismatches < 10)
                $display("%0t: %s expected %h got %h", $realtime, field_name[f],
                         exp_ghost.word[f], got_ghost.word[f]);
              bad = 1'b1;
            end
          end
          if (exp_ghost.axes !== got_ghost.axes) begin
            if (mismatches < 10)
              $display("%0t: mirrored_axes expected %b got %b", $realtime,
                       exp_ghost.axes, got_ghost.axes);
            bad = 1'b1;
          end
          if (exp_ghost.last !== got_ghost.last) begin
            if (mismatches < 10)
              $display("%0t: last_ghost expected %b got %b", $realtime,
                       exp_ghost.last, got_ghost.last);
            bad = 1'b1;
          end
          if (bad) mismatches++;
        end
      end
    end
    ghosts_pending = due_count;
  end

endmodule

/* tb/testbench.sv */
// Top of the ghost particle mirror test: clock, reset, particle and config
// stimulus, random back-pressure and the verdict. Depends on bgpm_pkg,
// boundary_ghost_particle_mirror and ghost_mirror_checker.
module testbench
  import bgpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 12;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MID = 32'h0000_8000;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata = '0;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, pressure_in
  logic                 m_tvalid;
  logic                 m_tready;
  logic [DATA_W-1:0]    m_tdata;        // ghost_pos_x/y/z, ghost_vel_x/y/z, ghost_pressure
  logic [NUM_AXES-1:0]  m_tuser;        // mirrored_axes
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_BOX_MIN_X;
  logic [FIELD_W-1:0]   cfg_data = '0;

  int mismatches;
  int pending;
  int cycles = 0;
  bit src_calm = 1'b0;

  // stimulus-side view of the box, used to aim particles at the walls
  logic [31:0] cur_lo [3] = '{32'h0, 32'h0, 32'h0};
  logic [31:0] cur_hi [3] = '{ONE, ONE, ONE};
  logic [30:0] cur_cut = 31'd6554;

  always #10 clk = ~clk;

  boundary_ghost_particle_mirror dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ghost_mirror_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .ghosts_pending(pending)
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinate near a wall, mid-box, or anywhere
  function automatic logic [31:0] pick_coord(input logic [31:0] lo, input logic [31:0] hi,
                                             input logic [30:0] cut);
    logic signed [63:0] sp, base, off, v;
    int r;
    sp = {33'd0, cut};
    sp = sp * 2 + 16;
    if (sp > 64'sh3FFF_FFFF) sp = 64'sh3FFF_FFFF;
    r = $urandom_range(0, 9);
    if (r == 9) return $urandom;
    if (r < 4) base = $signed(lo);
    else if (r < 7) base = $signed(hi);
    else begin
      base = $signed(lo);
      base = (base + $signed(hi)) >>> 1;
    end
    off = {32'd0, $urandom_range(0, 32'(sp * 2))};
    v = base + off - sp;
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  // Velocity or pressure: extremes, small values, or any pattern
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return NEG_MAX;
    if (r == 1) return POS_MAX;
    if (r == 2) return 32'($urandom_range(0, 511)) - 32'd256;
    return $urandom;
  endfunction

  // Offer one particle beat and hold it until accepted
  task automatic send(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                      input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
                      input logic [31:0] pr);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pr, vz, vy, vx, pz, py, px};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait out every outstanding ghost plus the pipeline depth
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic put_reg(input reg_index_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Reprogram the whole box once the block is idle
  task automatic set_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                         input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz,
                         input logic [31:0] cut, input logic [31:0] scale);
    settle();
    put_reg(REG_BOX_MIN_X, lx);
    put_reg(REG_BOX_MIN_Y, ly);
    put_reg(REG_BOX_MIN_Z, lz);
    put_reg(REG_BOX_MAX_X, hx);
    put_reg(REG_BOX_MAX_Y, hy);
    put_reg(REG_BOX_MAX_Z, hz);
    put_reg(REG_CUTOFF, cut);
    put_reg(REG_PRESSURE_SCALE, scale);
    cfg_we <= 1'b0;
    cur_lo  = '{lx, ly, lz};
    cur_hi  = '{hx, hy, hz};
    cur_cut = cut[30:0];
  endtask

  // Result-side back-pressure, with calm stretches of constant ready
  initial begin
    int stall_left;
    int span;
    bit sink_calm;
    stall_left = 0;
    span = 0;
    sink_calm = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
        span = 60;
      end
      span--;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!sink_calm) stall_left = pick_gap();
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("boundary_ghost_particle_mirror test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] lo, width;
    logic [31:0] lx [3];
    logic [31:0] hx [3];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset box [0, 1.0), cutoff 0.1, unit pressure scale
    send(MID, MID, MID, 32'd1, 32'd2, 32'd3, ONE);                      // no wall close
    send(32'd100, MID, MID, NEG_MAX, 32'd5, 32'd6, POS_MAX);            // x only, velocity clamp
    send(MID, ONE - 32'd10, MID, 32'd7, POS_MAX, 32'd8, NEG_MAX);       // upper y only
    send(32'd0, 32'd65535, 32'd6553, 32'd9, 32'hFFFF_FFF0, 32'd11, 32'hFFFF_FFFF); // all axes
    send(32'd6554, MID, ONE - 32'd6553, 32'd12, 32'd13, 32'd14, 32'd0); // cutoff boundary
    send(NEG_MAX, MID, POS_MAX, 32'd15, 32'd16, NEG_MAX, 32'd300);      // far outside, saturate
    send(MID, 32'hFFFF_FFFF, MID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // narrow box: both walls within cutoff, pressure ties at 1.5
    set_box(-32'd100, -32'd100, -32'd100, 32'd100, 32'd100, 32'd100, 32'd1000, 32'h0180);
    send(32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3, 32'd1);
    send(-32'd100, 32'd100, 32'd5000, 32'd4, NEG_MAX, 32'd6, 32'hFFFF_FFFF);
    send(32'd3, 32'd3, 32'd3, POS_MAX, 32'd0, NEG_MAX, POS_MAX);
    send(-32'd7, 32'd50, -32'd20, 32'd8, 32'd9, 32'd10, NEG_MAX);

    // widest box and cutoff, full pressure scale: saturation on both walls
    set_box(NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 32'h0000_FFFF);
    send(-32'd5, 32'd100, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd3, 32'd2);
    send(NEG_MAX, POS_MAX, 32'd0, NEG_MAX, NEG_MAX, NEG_MAX, ONE);
    send(-32'd2, -32'd2, -32'd2, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    send(32'd1, 32'hFFFF_FFFE, POS_MAX, 32'd4, 32'd5, 32'd6, NEG_MAX);

    // inverted box, zero cutoff, zero pressure scale
    set_box(ONE, ONE, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send(MID, 32'h0002_0000, ONE, 32'd1, 32'd2, 32'd3, 32'd12345);
    send(ONE, ONE, ONE, NEG_MAX, 32'd0, POS_MAX, NEG_MAX);
    send(32'd0, 32'hFFFF_0000, 32'h0001_8000, 32'd7, 32'd8, 32'd9, POS_MAX);

    // random phases, every third with unconstrained register patterns
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) begin
        set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
      end else begin
        for (int a = 0; a < 3; a++) begin
          lo    = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
          width = $urandom_range(1, 32'h0010_0000);
          lx[a] = lo;
          hx[a] = lo + width;
        end
        set_box(lx[0], lx[1], lx[2], hx[0], hx[1], hx[2],
                $urandom_range(0, 32'h0008_0000), $urandom_range(0, 65535));
      end
      for (int i = 0; i < 25; i++) begin
        if (i % 16 == 0) src_calm = ($urandom_range(0, 2) == 0);
        send(pick_coord(cur_lo[0], cur_hi[0], cur_cut),
             pick_coord(cur_lo[1], cur_hi[1], cur_cut),
             pick_coord(cur_lo[2], cur_hi[2], cur_cut),
             pick_value(), pick_value(), pick_value(), pick_value());
      end
      src_calm = 1'b0;
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("boundary_ghost_particle_mirror test passed");
    else
      $display("boundary_ghost_particle_mirror test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/bgpm_pkg.sv
rtl/bgpm_queue.sv
rtl/bgpm_front.sv
rtl/bgpm_back.sv
rtl/boundary_ghost_particle_mirror.sv
tb/ghost_mirror_checker.sv
tb/testbench.sv
